/* src/xtrg_pkg.sv */
// ----------------------------------------------------------------------------
// xtrg_pkg
// Shared types and constants for the XYZ to gamma RGB pixel pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package xtrg_pkg;

   localparam int COEF_BITS = 14;
   localparam int NUM_CHAN  = 3;
   localparam int NUM_STEPS = 8;   // one root cell per result bit
   localparam int PROD_W    = 34;  // 17b signed pixel x 17b signed coef
   localparam int SUM_W     = 36;  // row sums plus spill, with headroom
   localparam int REM_W     = 16;
   localparam int ROOT_W    = 16;

   typedef logic signed [16:0] coef_type;

   // Q2.14 matrix, rows are R, G, B
   localparam coef_type COEF_MAT [NUM_CHAN][NUM_CHAN] = '{
      '{ 17'sd38742, -17'sd14689, -17'sd7669 },
      '{ -17'sd8440, 17'sd23370,  17'sd1454  },
      '{ 17'sd85,    -17'sd236,   17'sd16535 }
   };

   // word handed along the root chain
   typedef struct packed {
      logic [NUM_CHAN-1:0][REM_W-1:0]  rem;
      logic [NUM_CHAN-1:0][ROOT_W-1:0] root;
      logic [NUM_CHAN-1:0]             sat;
   } root_word_type;

endpackage

`default_nettype wire

/* src/xtrg_req_if.sv */
// ----------------------------------------------------------------------------
// xtrg_req_if
// Pixel input channel: X, Y, Z words with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface xtrg_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] x_in;
   logic [15:0] y_in;
   logic [15:0] z_in;

   modport source (output valid, output x_in, output y_in, output z_in, input ready);
   modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

`default_nettype wire

/* src/xtrg_rsp_if.sv */
// ----------------------------------------------------------------------------
// xtrg_rsp_if
// Pixel result channel: gamma encoded R, G, B with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface xtrg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   output ready);
endinterface

`default_nettype wire

/* src/xtrg_front.sv */
// ----------------------------------------------------------------------------
// xtrg_front
// Matrix multiply, highlight spill, clip and scaling to 16 fraction bits.
// ----------------------------------------------------------------------------
`default_nettype none

module xtrg_front import xtrg_pkg::*; #(
   parameter int FRAC_BITS = 12
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          up_valid,
   output logic               up_ready,
   input  wire logic [15:0]   x_in,
   input  wire logic [15:0]   y_in,
   input  wire logic [15:0]   z_in,
   output logic               dn_valid,
   input  wire logic          dn_ready,
   output root_word_type      dn_word
);

   localparam int SHIFT = FRAC_BITS + COEF_BITS - 16;
   localparam logic signed [SUM_W-1:0] ONE_VAL = SUM_W'(1) <<< (FRAC_BITS + COEF_BITS);

   logic [15:0] pix [NUM_CHAN];

   logic                     s1_valid_ff, s1_valid_in, s1_ready;
   logic                     s2_valid_ff, s2_valid_in, s2_ready;
   logic                     s3_valid_ff, s3_valid_in, s3_ready;

   logic signed [PROD_W-1:0] prod_ff [NUM_CHAN][NUM_CHAN];
   logic signed [PROD_W-1:0] prod_in [NUM_CHAN][NUM_CHAN];
   logic signed [SUM_W-1:0]  lin_ff  [NUM_CHAN];
   logic signed [SUM_W-1:0]  lin_in  [NUM_CHAN];
   logic signed [SUM_W-1:0]  ov_ff   [NUM_CHAN];
   logic signed [SUM_W-1:0]  ov_in   [NUM_CHAN];
   root_word_type            word_ff, word_in;

   assign pix[0] = x_in;
   assign pix[1] = y_in;
   assign pix[2] = z_in;

   assign s3_ready = !s3_valid_ff || dn_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign up_ready = s1_ready;

   assign s1_valid_in = s1_ready ? up_valid    : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_comb begin
      for (int r = 0; r < NUM_CHAN; r++) begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            prod_in[r][c] = PROD_W'($signed({1'b0, pix[c]}) * COEF_MAT[r][c]);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < NUM_CHAN; r++) begin
         lin_in[r] = SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1]) + SUM_W'(prod_ff[r][2]);
         ov_in[r]  = (lin_in[r] > ONE_VAL) ? lin_in[r] - ONE_VAL : '0;
      end
   end

   // spill the other two channels' excess in, clip at zero, drop to 16 fraction bits
   always_comb begin
      logic signed [SUM_W-1:0] chan;
      logic [SUM_W-1:0]        scaled;
      word_in = '0;
      for (int r = 0; r < NUM_CHAN; r++) begin
         chan = lin_ff[r] + ov_ff[(r + 1) % NUM_CHAN] + ov_ff[(r + 2) % NUM_CHAN];
         scaled = SUM_W'(unsigned'(chan)) >> SHIFT;
         if (chan <= 0) begin
            word_in.rem[r] = '0;
            word_in.sat[r] = 1'b0;
         end else if (scaled[SUM_W-1:16] != '0) begin
            word_in.rem[r] = '0;
            word_in.sat[r] = 1'b1;
         end else begin
            word_in.rem[r] = scaled[REM_W-1:0];
            word_in.sat[r] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
      if (up_valid && s1_ready) prod_ff <= prod_in;
      if (s1_valid_ff && s2_ready) begin
         lin_ff <= lin_in;
         ov_ff  <= ov_in;
      end
      if (s2_valid_ff && s3_ready) word_ff <= word_in;
   end

   assign dn_valid = s3_valid_ff;
   assign dn_word  = word_ff;

endmodule

`default_nettype wire

/* src/xtrg_root_cell.sv */
// ----------------------------------------------------------------------------
// xtrg_root_cell
// One restoring square root step for all three channels, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module xtrg_root_cell import xtrg_pkg::*; #(
   parameter int STEP = 0
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    up_valid,
   output logic         up_ready,
   input  root_word_type up_word,
   output logic         dn_valid,
   input  wire logic    dn_ready,
   output root_word_type dn_word
);

   localparam logic [ROOT_W:0] BIT_VAL = (ROOT_W + 1)'(1) << (14 - 2 * STEP);

   logic          valid_ff, valid_in;
   root_word_type word_ff, word_in;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      logic [ROOT_W:0] trial;
      word_in = up_word;
      for (int c = 0; c < NUM_CHAN; c++) begin
         trial = {1'b0, up_word.root[c]} + BIT_VAL;
         if ({1'b0, up_word.rem[c]} >= trial) begin
            word_in.rem[c]  = REM_W'({1'b0, up_word.rem[c]} - trial);
            word_in.root[c] = ROOT_W'({1'b0, up_word.root[c] >> 1} + BIT_VAL);
         end else begin
            word_in.root[c] = up_word.root[c] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_valid && up_ready) word_ff <= word_in;
   end

   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

endmodule

`default_nettype wire

/* src/xyz_to_rgb_gamma_pixel.sv */
// ----------------------------------------------------------------------------
// xyz_to_rgb_gamma_pixel
// CIE XYZ (Q4.12) to square-root gamma encoded 8-bit RGB, one pixel a cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one pixel word (x_in, y_in, z_in); rsp_bus returns one
//   word (red_out, green_out, blue_out) per pixel, in order. Both channels
//   are valid/ready; a word moves on a clock edge with both high.
//   An accepted word reaches rsp_bus.valid through eleven register stages:
//   three front stages (multiply, row sum with excess, spill/clip/scale)
//   and a chain of eight root cells, each resolving one result bit.
//   Throughput is one pixel per cycle while rsp_bus is not stalled, set by
//   the cell chain which accepts a new word every cycle that it is ready.
//   Each stage has its own valid bit and a ready of its own, so a stalled
//   receiver only holds the last cell; earlier empty stages keep filling
//   and req_bus.ready drops only when every stage holds a word.
//   Synchronous reset empties the pipeline; no word is in flight after it.
// ----------------------------------------------------------------------------
`default_nettype none

module xyz_to_rgb_gamma_pixel import xtrg_pkg::*; #(
   parameter int FRAC_BITS = 12
) (
   input  wire logic  clock,
   input  wire logic  reset,
   xtrg_req_if.sink   req_bus,
   xtrg_rsp_if.source rsp_bus
);

   logic          chain_valid [NUM_STEPS+1];
   logic          chain_ready [NUM_STEPS+1];
   root_word_type chain_word  [NUM_STEPS+1];

   xtrg_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_bus.valid),
      .up_ready (req_bus.ready),
      .x_in     (req_bus.x_in),
      .y_in     (req_bus.y_in),
      .z_in     (req_bus.z_in),
      .dn_valid (chain_valid[0]),
      .dn_ready (chain_ready[0]),
      .dn_word  (chain_word[0])
   );

   for (genvar s = 0; s < NUM_STEPS; s++) begin : g_cell
      xtrg_root_cell #(.STEP(s)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[s]),
         .up_ready (chain_ready[s]),
         .up_word  (chain_word[s]),
         .dn_valid (chain_valid[s+1]),
         .dn_ready (chain_ready[s+1]),
         .dn_word  (chain_word[s+1])
      );
   end

   assign chain_ready[NUM_STEPS] = rsp_bus.ready;
   assign rsp_bus.valid = chain_valid[NUM_STEPS];

   assign rsp_bus.red_out   = chain_word[NUM_STEPS].sat[0] ? 8'hFF
                                                           : chain_word[NUM_STEPS].root[0][7:0];
   assign rsp_bus.green_out = chain_word[NUM_STEPS].sat[1] ? 8'hFF
                                                           : chain_word[NUM_STEPS].root[1][7:0];
   assign rsp_bus.blue_out  = chain_word[NUM_STEPS].sat[2] ? 8'hFF
                                                           : chain_word[NUM_STEPS].root[2][7:0];

endmodule

`default_nettype wire

/* src/xtrg_checker.sv */
// ----------------------------------------------------------------------------
// xtrg_checker
// Port-level checks on the pixel pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module xtrg_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] red_out,
   input wire logic [7:0] green_out,
   input wire logic [7:0] blue_out
);

   // pipeline is empty straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // an unstalled output lets the whole chain move, so the input must be open
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      (rsp_ready || !rsp_valid) |-> req_ready)
      else $error("input blocked while output drains");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(red_out) && $stable(green_out) && $stable(blue_out))
      else $error("result word changed while stalled");

endmodule

bind xyz_to_rgb_gamma_pixel xtrg_checker u_xtrg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .red_out   (rsp_bus.red_out),
   .green_out (rsp_bus.green_out),
   .blue_out  (rsp_bus.blue_out)
);

`default_nettype wire
